>>> design/instruction_prefetch_buffer_macros.svh
// assertion macros used by the prefetch buffer checker
`ifndef INSTRUCTION_PREFETCH_BUFFER_MACROS_SVH
`define INSTRUCTION_PREFETCH_BUFFER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define IPB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define IPB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ipb_pkg.sv
// shared types, codes and defaults of the instruction prefetch buffer
package ipb_pkg;

  // default line size in 32-bit words
  localparam int ACCESS_WORDS_DEF = 1;

  // base address of an empty line
  localparam logic [31:0] BASE_NONE = 32'hFFFF_FFFF;

  // input item kinds
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_GET   = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_READY = 2'd1;
  localparam logic [1:0] STATUS_NO_SYNC   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] pc_value;
    logic        execute_stalled;
    logic        reply_ready;
    logic [31:0] reply_data;
    logic        request_accepted;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] inst_halfword;
    logic        pc_write;
    logic [31:0] next_pc;
    logic        load_request;
    logic [31:0] load_address;
    logic        fetch_cycle;
  } result_t;

endpackage

>>> design/ipb_channels.sv
// valid/ready channel interfaces for the input and result beats

interface ipb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] pc_value;
  logic        execute_stalled;
  logic        reply_ready;
  logic [31:0] reply_data;
  logic        request_accepted;

  modport source (
    output valid, mode, pc_value, execute_stalled, reply_ready, reply_data,
           request_accepted,
    input  ready
  );
  modport sink (
    input  valid, mode, pc_value, execute_stalled, reply_ready, reply_data,
           request_accepted,
    output ready
  );
endinterface

interface ipb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] inst_halfword;
  logic        pc_write;
  logic [31:0] next_pc;
  logic        load_request;
  logic [31:0] load_address;
  logic        fetch_cycle;

  modport source (
    output valid, status, inst_halfword, pc_write, next_pc, load_request,
           load_address, fetch_cycle,
    input  ready
  );
  modport sink (
    input  valid, status, inst_halfword, pc_write, next_pc, load_request,
           load_address, fetch_cycle,
    output ready
  );
endinterface

>>> design/ipb_core.sv
// line state of the prefetch buffer and the per-beat result logic
module ipb_core #(
  parameter int ACCESS_WORDS = ipb_pkg::ACCESS_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  ipb_pkg::in_beat_t beat,
  output ipb_pkg::result_t  res
);

  localparam int LINE_HW    = 2 * ACCESS_WORDS;
  localparam int LINE_BYTES = 4 * ACCESS_WORDS;
  localparam int OFFS_W     = $clog2(LINE_BYTES);
  localparam int IDX_W      = OFFS_W - 1;
  localparam logic [31:0] BASE_MASK = ~(32'(LINE_BYTES) - 32'd1);

  logic [15:0] hw_r   [LINE_HW];
  logic [15:0] hw_nxt [LINE_HW];
  logic [31:0] base_r, base_nxt;
  logic        valid_r, valid_nxt;
  logic        flush_r, flush_nxt;
  logic        outst_r, outst_nxt;

  logic [31:0] pc_base;
  logic [31:0] pc_plus2;
  logic [31:0] probe;
  logic        req;
  logic [IDX_W-1:0] hw_idx;

  assign pc_base  = beat.pc_value & BASE_MASK;
  assign pc_plus2 = 32'(beat.pc_value + 32'd2);
  assign hw_idx   = beat.pc_value[OFFS_W-1:1];

  // next state and result for the beat on the input
  always_comb begin
    for (int i = 0; i < LINE_HW; i++) hw_nxt[i] = hw_r[i];
    base_nxt  = base_r;
    valid_nxt = valid_r;
    flush_nxt = flush_r;
    outst_nxt = outst_r;
    res       = '0;
    probe     = beat.pc_value;
    req       = 1'b0;

    case (beat.mode)
      ipb_pkg::MODE_FLUSH: begin
        flush_nxt = 1'b1;
      end
      ipb_pkg::MODE_GET: begin
        if (!valid_r || flush_r) begin
          res.status = ipb_pkg::STATUS_NOT_READY;
        end else if (pc_base != base_r) begin
          res.status = ipb_pkg::STATUS_NO_SYNC;
        end else begin
          res.inst_halfword = hw_r[hw_idx];
          res.pc_write      = 1'b1;
          res.next_pc       = pc_plus2;
        end
      end
      ipb_pkg::MODE_TICK: begin
        // apply a pending flush
        if (flush_r) begin
          for (int i = 0; i < LINE_HW; i++) hw_nxt[i] = '0;
          valid_nxt = 1'b0;
          base_nxt  = ipb_pkg::BASE_NONE;
          outst_nxt = 1'b0;
          flush_nxt = 1'b0;
        end
        // capture a returned line
        if (outst_nxt && beat.reply_ready) begin
          for (int i = 0; i < LINE_HW; i++) hw_nxt[i] = '0;
          hw_nxt[0] = beat.reply_data[15:0];
          hw_nxt[1] = beat.reply_data[31:16];
          valid_nxt = 1'b1;
          base_nxt  = pc_base;
          outst_nxt = 1'b0;
        end
        // decide on a new line request
        probe = valid_nxt ? pc_plus2 : beat.pc_value;
        req   = !valid_nxt ||
                (!beat.execute_stalled && ((probe & BASE_MASK) != base_nxt));
        if (req) begin
          if (beat.request_accepted) outst_nxt = 1'b1;
          res.load_request = 1'b1;
          res.load_address = probe;
          res.fetch_cycle  = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // state registers, updated on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_HW; i++) hw_r[i] <= '0;
      base_r  <= ipb_pkg::BASE_NONE;
      valid_r <= 1'b0;
      flush_r <= 1'b0;
      outst_r <= 1'b0;
    end else if (take) begin
      for (int i = 0; i < LINE_HW; i++) hw_r[i] <= hw_nxt[i];
      base_r  <= base_nxt;
      valid_r <= valid_nxt;
      flush_r <= flush_nxt;
      outst_r <= outst_nxt;
    end
  end

endmodule

>>> design/ipb_skid.sv
// result register with a skid stage so one more input is taken during a stall
module ipb_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ipb_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ipb_pkg::result_t out_data
);

  logic             out_valid_r;
  logic             skid_valid_r;
  ipb_pkg::result_t out_data_r;
  ipb_pkg::result_t skid_data_r;
  logic             take;

  assign in_ready  = !skid_valid_r;
  assign take      = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= take;
      end
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : in_data;
    end else if (take) begin
      skid_data_r <= in_data;
    end
  end

endmodule

>>> design/instruction_prefetch_buffer.sv
// top level of the instruction prefetch buffer
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    mode, pc_value, execute_stalled, reply_ready,
//                                reply_data, request_accepted
//   out_ch   out  valid/ready    status, inst_halfword, pc_write, next_pc,
//                                load_request, load_address, fetch_cycle
//
// one beat per cycle while in_ch.ready is high; each input beat gives one result beat
// line state updates in the cycle a beat is accepted, result sits in an output register
// a two-entry output (register plus skid) holds results while out_ch stalls;
// in_ch.ready drops only when both are full
// synchronous active-low reset empties the line (base all ones) and the output
module instruction_prefetch_buffer #(
  parameter int ACCESS_WORDS = ipb_pkg::ACCESS_WORDS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ipb_in_if.sink    in_ch,
  ipb_out_if.source out_ch
);

  ipb_pkg::in_beat_t beat;
  ipb_pkg::result_t  res;
  ipb_pkg::result_t  out_data;
  logic              take;

  // pack the input beat
  assign beat.mode             = in_ch.mode;
  assign beat.pc_value         = in_ch.pc_value;
  assign beat.execute_stalled  = in_ch.execute_stalled;
  assign beat.reply_ready      = in_ch.reply_ready;
  assign beat.reply_data       = in_ch.reply_data;
  assign beat.request_accepted = in_ch.request_accepted;

  assign take = in_ch.valid && in_ch.ready;

  ipb_core #(
    .ACCESS_WORDS(ACCESS_WORDS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .take (take),
    .beat (beat),
    .res  (res)
  );

  ipb_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (res),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data (out_data)
  );

  // unpack the result beat
  assign out_ch.status        = out_data.status;
  assign out_ch.inst_halfword = out_data.inst_halfword;
  assign out_ch.pc_write      = out_data.pc_write;
  assign out_ch.next_pc       = out_data.next_pc;
  assign out_ch.load_request  = out_data.load_request;
  assign out_ch.load_address  = out_data.load_address;
  assign out_ch.fetch_cycle   = out_data.fetch_cycle;

endmodule

>>> design/ipb_checker.sv
// port-level assertions for the prefetch buffer, bound to the top level
`include "instruction_prefetch_buffer_macros.svh"

module ipb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_inst_halfword,
  input logic        out_pc_write,
  input logic [31:0] out_next_pc,
  input logic        out_load_request,
  input logic [31:0] out_load_address,
  input logic        out_fetch_cycle
);

  // a stalled result beat holds
  `IPB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_inst_halfword) && $stable(out_pc_write) && $stable(out_next_pc) && $stable(out_load_request) && $stable(out_load_address) && $stable(out_fetch_cycle), "stalled result beat changed")

  // an empty output never blocks the input
  `IPB_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input blocked with empty output")

  // a beat into an empty output shows up on the next cycle
  `IPB_ASSERT_NXT(a_latency, clk, rst_n, in_valid && in_ready && !out_valid, out_valid, "result beat missing one cycle after input")

  // a flush beat gives a quiet result
  `IPB_ASSERT_NXT(a_flush_quiet, clk, rst_n, in_valid && in_ready && !out_valid && (in_mode == ipb_pkg::MODE_FLUSH), (out_status == ipb_pkg::STATUS_OK) && !out_pc_write && !out_load_request && !out_fetch_cycle, "flush beat gave a non-empty result")

endmodule

bind instruction_prefetch_buffer ipb_checker u_ipb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_mode          (in_ch.mode),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_inst_halfword(out_ch.inst_halfword),
  .out_pc_write     (out_ch.pc_write),
  .out_next_pc      (out_ch.next_pc),
  .out_load_request (out_ch.load_request),
  .out_load_address (out_ch.load_address),
  .out_fetch_cycle  (out_ch.fetch_cycle)
);

>>> bench/tb_instruction_prefetch_buffer.sv
// testbench for the instruction prefetch buffer: directed table, then random fetch traffic
module tb_instruction_prefetch_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACCESS_WORDS = ipb_pkg::ACCESS_WORDS_DEF;
  localparam int LINE_HW = 2 * ACCESS_WORDS;
  localparam logic [31:0] LINE_MASK = ~(32'(4 * ACCESS_WORDS) - 32'd1);
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 700;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    ipb_pkg::in_beat_t beat;
    bit                typed;
    ipb_pkg::result_t  want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic steady;
  int   mismatches = 0;
  int   cycle_cnt = 0;

  ipb_in_if  in_ch ();
  ipb_out_if out_ch ();

  instruction_prefetch_buffer #(.ACCESS_WORDS(ACCESS_WORDS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // own copy of the line state
  logic [15:0] buf_hw [LINE_HW];
  logic [31:0] buf_base;
  logic        buf_valid;
  logic        flush_armed;
  logic        load_busy;
  logic [31:0] prog_pc;

  ipb_pkg::result_t fetch_results_due [$];
  plan_row_t        plan [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_instruction_prefetch_buffer: errors");
      $finish;
    end
  end

  function automatic logic [31:0] line_of(logic [31:0] addr);
    return addr & LINE_MASK;
  endfunction

  // advances the line state by one beat and returns the result it gives
  function automatic ipb_pkg::result_t prefetch_predict(ipb_pkg::in_beat_t b);
    ipb_pkg::result_t r;
    logic [31:0]      probe;
    r = '0;
    case (b.mode)
      ipb_pkg::MODE_FLUSH: flush_armed = 1'b1;
      ipb_pkg::MODE_GET: begin
        if (!buf_valid || flush_armed) begin
          r.status = ipb_pkg::STATUS_NOT_READY;
        end else if (line_of(b.pc_value) != buf_base) begin
          r.status = ipb_pkg::STATUS_NO_SYNC;
        end else begin
          r.status = ipb_pkg::STATUS_OK;
          r.inst_halfword = buf_hw[int'((b.pc_value >> 1) & 32'(LINE_HW - 1))];
          r.pc_write = 1'b1;
          r.next_pc = b.pc_value + 32'd2;
        end
      end
      ipb_pkg::MODE_TICK: begin
        // a pending flush empties the line first
        if (flush_armed) begin
          foreach (buf_hw[i]) buf_hw[i] = '0;
          buf_valid = 1'b0;
          buf_base = ipb_pkg::BASE_NONE;
          load_busy = 1'b0;
          flush_armed = 1'b0;
        end
        // returned data lands at the line of the current pc
        if (load_busy && b.reply_ready) begin
          foreach (buf_hw[i]) buf_hw[i] = '0;
          buf_hw[0] = b.reply_data[15:0];
          buf_hw[1 % LINE_HW] = b.reply_data[31:16];
          buf_valid = 1'b1;
          buf_base = line_of(b.pc_value);
          load_busy = 1'b0;
        end
        // request when empty, or when the next pc leaves the line and execute is not stalled
        probe = buf_valid ? b.pc_value + 32'd2 : b.pc_value;
        if (!buf_valid || (!b.execute_stalled && line_of(probe) != buf_base)) begin
          if (b.request_accepted) load_busy = 1'b1;
          r.load_request = 1'b1;
          r.load_address = probe;
          r.fetch_cycle = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic ipb_pkg::in_beat_t beat(logic [1:0] m, logic [31:0] pc, logic st,
                                             logic rr, logic [31:0] d, logic acc);
    ipb_pkg::in_beat_t b;
    b.mode = m;
    b.pc_value = pc;
    b.execute_stalled = st;
    b.reply_ready = rr;
    b.reply_data = d;
    b.request_accepted = acc;
    return b;
  endfunction

  function automatic ipb_pkg::result_t outcome(logic [1:0] st, logic [15:0] hw, logic pcw,
                                               logic [31:0] npc, logic lreq,
                                               logic [31:0] laddr, logic fc);
    ipb_pkg::result_t r;
    r.status = st;
    r.inst_halfword = hw;
    r.pc_write = pcw;
    r.next_pc = npc;
    r.load_request = lreq;
    r.load_address = laddr;
    r.fetch_cycle = fc;
    return r;
  endfunction

  task automatic add_row(ipb_pkg::in_beat_t b, bit typed = 1'b0,
                         ipb_pkg::result_t want = '0);
    plan_row_t row;
    row.beat = b;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  // mostly a running program: sequential pcs, ticks and gets, replies when a load is out
  function automatic ipb_pkg::in_beat_t random_beat();
    ipb_pkg::in_beat_t b;
    int                p;
    p = $urandom_range(99);
    b.mode = p < 50 ? ipb_pkg::MODE_TICK : p < 86 ? ipb_pkg::MODE_GET :
             p < 96 ? ipb_pkg::MODE_FLUSH : MODE_UNUSED;
    p = $urandom_range(99);
    if (p < 6) begin
      prog_pc = $urandom() & ~32'd1;
    end else if (p < 9) begin
      prog_pc = 32'hFFFF_FFF8 + 32'($urandom_range(7));
    end else if (p < 12) begin
      prog_pc = 32'($urandom_range(7));
    end else if (p < 14) begin
      prog_pc = $urandom();
    end
    b.pc_value = ($urandom_range(99) < 6) ? prog_pc + 32'(2 * $urandom_range(1, 3)) : prog_pc;
    b.execute_stalled = $urandom_range(99) < 25;
    b.reply_ready = load_busy ? ($urandom_range(99) < 85) : 1'($urandom_range(1));
    b.reply_data = $urandom();
    b.request_accepted = $urandom_range(99) < 85;
    return b;
  endfunction

  // one input beat: random gaps, then hold until accepted
  task automatic send_beat(ipb_pkg::in_beat_t b, bit typed, ipb_pkg::result_t want);
    ipb_pkg::result_t due;
    while (!steady && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= b.mode;
    in_ch.pc_value <= b.pc_value;
    in_ch.execute_stalled <= b.execute_stalled;
    in_ch.reply_ready <= b.reply_ready;
    in_ch.reply_data <= b.reply_data;
    in_ch.request_accepted <= b.request_accepted;
    do @(posedge clk); while (!in_ch.ready);
    due = prefetch_predict(b);
    fetch_results_due.push_back(typed ? want : due);
    if (due.pc_write) prog_pc = due.next_pc;
    @(negedge clk);
  endtask

  // stop sending until every result is back
  task automatic let_results_drain();
    in_ch.valid <= 1'b0;
    while (fetch_results_due.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= 19);
    end
  end

  // result beats against the oldest expectation
  always @(posedge clk) begin
    ipb_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (fetch_results_due.size() == 0) begin
        $display("%0t: result beat with nothing due, expected none, got status %h",
                 $time, out_ch.status);
        mismatches++;
      end else begin
        want = fetch_results_due.pop_front();
        compare_field("status", want.status, out_ch.status);
        compare_field("inst_halfword", want.inst_halfword, out_ch.inst_halfword);
        compare_field("pc_write", want.pc_write, out_ch.pc_write);
        compare_field("next_pc", want.next_pc, out_ch.next_pc);
        compare_field("load_request", want.load_request, out_ch.load_request);
        compare_field("load_address", want.load_address, out_ch.load_address);
        compare_field("fetch_cycle", want.fetch_cycle, out_ch.fetch_cycle);
      end
    end
  end

  initial begin
    ipb_pkg::in_beat_t b;
    int                counted;

    // all inputs known from time zero
    rst_n = 1'b0;
    steady = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = ipb_pkg::MODE_TICK;
    in_ch.pc_value = '0;
    in_ch.execute_stalled = 1'b0;
    in_ch.reply_ready = 1'b0;
    in_ch.reply_data = '0;
    in_ch.request_accepted = 1'b0;
    foreach (buf_hw[i]) buf_hw[i] = '0;
    buf_base = ipb_pkg::BASE_NONE;
    buf_valid = 1'b0;
    flush_armed = 1'b0;
    load_busy = 1'b0;
    prog_pc = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // a get right after reset finds an empty line
    add_row(beat(ipb_pkg::MODE_GET, 32'h0, 0, 0, 0, 0), 1,
            outcome(ipb_pkg::STATUS_NOT_READY, 0, 0, 0, 0, 0, 0));
    // the unused mode is ignored
    add_row(beat(MODE_UNUSED, '1, 1, 1, '1, 1), 1, '0);
    // empty line asks for pc, refused then taken
    add_row(beat(ipb_pkg::MODE_TICK, 32'h1000, 0, 0, 0, 0), 1,
            outcome(ipb_pkg::STATUS_OK, 0, 0, 0, 1, 32'h1000, 1));
    add_row(beat(ipb_pkg::MODE_TICK, 32'h1000, 0, 1, 32'h1234_5678, 1), 1,
            outcome(ipb_pkg::STATUS_OK, 0, 0, 0, 1, 32'h1000, 1));
    // reply lands, both halfwords, then a get outside the line
    add_row(beat(ipb_pkg::MODE_TICK, 32'h1000, 0, 1, 32'hBEEF_CAFE, 0));
    add_row(beat(ipb_pkg::MODE_GET, 32'h1000, 1, 1, '1, 1));
    add_row(beat(ipb_pkg::MODE_GET, 32'h1002, 0, 0, 0, 0));
    add_row(beat(ipb_pkg::MODE_GET, 32'h1004, 0, 0, 0, 0));
    // stalled tick holds back the next line, unstalled one asks for it
    add_row(beat(ipb_pkg::MODE_TICK, 32'h1002, 1, 0, 0, 1));
    add_row(beat(ipb_pkg::MODE_TICK, 32'h1002, 0, 0, 0, 1));
    add_row(beat(ipb_pkg::MODE_TICK, 32'h1004, 0, 1, 32'hFFFF_0000, 0));
    add_row(beat(ipb_pkg::MODE_GET, 32'h1006, 0, 0, 0, 0));
    // flush blocks gets until the next tick
    add_row(beat(ipb_pkg::MODE_FLUSH, 32'h1004, 1, 1, '1, 1), 1, '0);
    add_row(beat(ipb_pkg::MODE_GET, 32'h1004, 0, 0, 0, 0), 1,
            outcome(ipb_pkg::STATUS_NOT_READY, 0, 0, 0, 0, 0, 0));
    add_row(beat(ipb_pkg::MODE_TICK, 32'hFFFF_FFFC, 0, 1, 0, 1), 1,
            outcome(ipb_pkg::STATUS_OK, 0, 0, 0, 1, 32'hFFFF_FFFC, 1));
    // top of memory: pc plus two wraps to zero
    add_row(beat(ipb_pkg::MODE_TICK, 32'hFFFF_FFFE, 0, 1, '1, 0));
    add_row(beat(ipb_pkg::MODE_GET, 32'hFFFF_FFFE, 0, 0, 0, 0));
    add_row(beat(ipb_pkg::MODE_GET, 32'hFFFF_FFFF, 0, 0, 0, 0));
    add_row(beat(ipb_pkg::MODE_GET, 32'h0, 0, 0, 0, 0));
    // back-to-back flushes, a stalled tick still refills an empty line
    add_row(beat(ipb_pkg::MODE_FLUSH, 32'h0, 0, 0, 0, 0), 1, '0);
    add_row(beat(ipb_pkg::MODE_FLUSH, '1, 1, 1, '1, 1), 1, '0);
    add_row(beat(ipb_pkg::MODE_TICK, 32'h0, 1, 1, '1, 1), 1,
            outcome(ipb_pkg::STATUS_OK, 0, 0, 0, 1, 32'h0, 1));
    add_row(beat(ipb_pkg::MODE_GET, 32'h0, 1, 1, '1, 1), 1,
            outcome(ipb_pkg::STATUS_NOT_READY, 0, 0, 0, 0, 0, 0));
    add_row(beat(ipb_pkg::MODE_TICK, 32'h2, 0, 1, 32'h8001_7FFE, 0));

    foreach (plan[i]) send_beat(plan[i].beat, plan[i].typed, plan[i].want);
    let_results_drain();

    // random traffic, with a quiet stretch and a full drain halfway
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      b = random_beat();
      send_beat(b, 1'b0, '0);
      if (b.mode != MODE_UNUSED) begin
        counted++;
        if (counted == RANDOM_BEATS / 2) let_results_drain();
      end
      steady <= (counted >= 200 && counted < 320);
    end

    let_results_drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_instruction_prefetch_buffer: clean");
    end else begin
      $display("tb_instruction_prefetch_buffer: errors");
    end
    $finish;
  end

endmodule
